// File: src/bps_pkg.sv
package bps_pkg;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int LEN_W = 4;
  localparam int PAT_W = 64;
  localparam int SYM_W = 9;
  localparam int OFF_W = 24;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;
  localparam int QUEUE_DEPTH = 2;

  // substitution code bases
  localparam logic [SYM_W-1:0] CODE_SHORT = SYM_W'(256 + 23);
  localparam logic [SYM_W-1:0] CODE_TOP = SYM_W'(256 + 26);
  localparam logic [LEN_W-1:0] SHORT_LIMIT = LEN_W'(4);

  // register index, taken from paddr[3]
  localparam logic REG_LENGTH = 1'b0;
  localparam logic REG_PATTERN = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [SYM_W-1:0] first_code;
    logic [PAT_W-1:0] pattern;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic eos;
  } item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic is_code;
    logic [OFF_W-1:0] dump_offset;
    logic last_of_run;
  } res_t;

endpackage

// File: src/bps_fifo.sv
module bps_fifo
  import bps_pkg::*;
#(
  parameter int W = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  // DEPTH must be a power of two so the pointers wrap on their own
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (DEPTH > 1) ? wr_ptr_r + 1'b1 : '0;
      end
      if (do_pop) begin
        rd_ptr_r <= (DEPTH > 1) ? rd_ptr_r + 1'b1 : '0;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: src/bps_cfg.sv
module bps_cfg
  import bps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output cfg_t              cfg
);

  logic [LEN_W-1:0] length_r;
  logic [PAT_W-1:0] pattern_r;
  logic [LEN_W-1:0] eff_len;
  logic             wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r  <= LEN_W'(1);
      pattern_r <= '0;
    end else if (wr_en) begin
      if (paddr[3] == REG_LENGTH) begin
        length_r <= pwdata[LEN_W-1:0];
      end else begin
        pattern_r <= pwdata[PAT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[3] == REG_PATTERN) ? pattern_r
                                            : {{(CFG_DW-LEN_W){1'b0}}, length_r};

  // zero acts as one, anything past the window depth as the depth
  always_comb begin
    eff_len = length_r;
    if (length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (length_r > LEN_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end
  end

  assign cfg.len        = eff_len;
  assign cfg.first_code = (eff_len < SHORT_LIMIT) ? CODE_SHORT
                                                  : CODE_TOP - SYM_W'(eff_len);
  assign cfg.pattern    = pattern_r;

endmodule

// File: src/bps_engine.sv
module bps_engine
  import bps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_empty,
  input  item_t q_item,
  output logic  q_pop,
  input  logic  res_full,
  output logic  res_push,
  output res_t  res
);

  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0]       win_r [MAX_PATTERN];
  logic [7:0]       w     [MAX_PATTERN];
  logic [7:0]       w_sh  [MAX_PATTERN];
  logic [LEN_W-1:0] fill_r, code_idx_r;
  logic             eos_r, run_r;
  logic [OFF_W-1:0] pos_r;

  logic [LEN_W-1:0] cnt, cnt_after, code_inc, code_next;
  logic             eos, take, act, emit, match, is_code, more;

  // a new byte enters only between runs; a run drains one result a cycle while res_full is low
  assign take  = !run_r && !q_empty && !res_full;
  assign q_pop = take;
  assign act   = (take || run_r) && !res_full;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w[i] = win_r[i];
    end
    cnt = fill_r;
    eos = eos_r;
    if (take) begin
      w[fill_r[IW-1:0]] = q_item.data_byte;
      cnt = fill_r + 1'b1;
      eos = q_item.eos;
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w_sh[i] = (i < MAX_PATTERN - 1) ? w[(i + 1) % MAX_PATTERN] : w[i];
    end

    match = (code_idx_r == '0) && (cnt >= cfg.len);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((LEN_W'(k) < cfg.len) && (w[k] != cfg.pattern[8*k +: 8])) begin
        match = 1'b0;
      end
    end

    is_code   = (code_idx_r != '0) || match;
    code_inc  = code_idx_r + 1'b1;
    code_next = '0;
    if (is_code && (code_inc != cfg.len)) begin
      code_next = code_inc;
    end
    cnt_after = cnt - 1'b1;
    more = (code_next != '0) || (cnt_after >= cfg.len) || (eos && (cnt_after != '0));
    emit = act && ((code_idx_r != '0) || (cnt >= cfg.len) || (eos && (cnt != '0)));
  end

  assign res_push        = emit;
  assign res.symbol      = is_code ? cfg.first_code + SYM_W'(code_idx_r) : {1'b0, w[0]};
  assign res.is_code     = is_code;
  assign res.dump_offset = pos_r;
  assign res.last_of_run = !more;

  always_ff @(posedge clk) begin
    if (act) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_r[i] <= emit ? w_sh[i] : w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      code_idx_r <= '0;
      eos_r      <= 1'b0;
      run_r      <= 1'b0;
      pos_r      <= '0;
    end else if (act) begin
      if (emit) begin
        fill_r     <= cnt_after;
        code_idx_r <= code_next;
        eos_r      <= eos && more;
        run_r      <= more;
        pos_r      <= pos_r + 1'b1;
      end else begin
        fill_r <= cnt;
        eos_r  <= eos;
      end
    end
  end

endmodule

// File: src/byte_pattern_substituter.sv
// Channel  | Ports                                              | Transfer when
// ---------+----------------------------------------------------+---------------------
// input    | in_push, in_full, in_data_byte, in_end_of_stream   | push & !full
// result   | out_pop, out_empty, out_symbol, out_is_code,       | pop & !empty
//          | out_dump_offset, out_last_of_run                   |
// config   | cfg_psel/penable/pwrite/paddr/pwdata/prdata/pready | psel&penable&pwrite
//
// One byte a cycle sustained while the result queue has room; a byte that triggers
// a match or a flush holds back later bytes while the engine issues its extra results.
// The window engine issues one result per cycle when the result queue is not full.
// Input and result queues are two deep each, so either side may stall independently.
// rst_n is synchronous; reset empties both queues and the window.
module byte_pattern_substituter
  import bps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_stream,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [SYM_W-1:0]  out_symbol,
  output logic              out_is_code,
  output logic [OFF_W-1:0]  out_dump_offset,
  output logic              out_last_of_run,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t  cfg;
  item_t in_item, q_item;
  logic  q_empty, q_pop;
  res_t  res, out_res;
  logic  res_push, res_full;

  assign cfg_pready = 1'b1;
  assign in_item.data_byte = in_data_byte;
  assign in_item.eos       = in_end_of_stream;

  bps_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  bps_fifo #(.W($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_item),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  bps_engine #(.MAX_PATTERN(MAX_PATTERN)) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  bps_fifo #(.W($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_symbol      = out_res.symbol;
  assign out_is_code     = out_res.is_code;
  assign out_dump_offset = out_res.dump_offset;
  assign out_last_of_run = out_res.last_of_run;

endmodule
